/* hdl/assert_macros.svh */
// Assertion helpers used by sorted_priority_queue_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge, off while reset is low.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// Next-cycle implication, checked on the rising edge, off while reset is low.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

/* hdl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEF_DEPTH     = 16;
    localparam int DEF_PRIO_BITS = 8;

    localparam int FIELD_W  = 8;   // in_prio, in_info, out_prio, out_info
    localparam int CFG_W    = 5;   // capacity register
    localparam int COUNT_W  = 5;   // count result field
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic enq;   // insert the broadcast entry
        logic deq;   // shift everything one place toward the head
    } t_cell_ctl;

endpackage

/* hdl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// broadcast entry, and moves data to or from its neighbors.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIO_BITS = DEF_PRIO_BITS
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [PRIO_BITS-1:0] i_new_prio,
    input  logic [FIELD_W-1:0]   i_new_info,
    input  logic                 i_occ,        // this slot holds an entry
    input  logic                 i_left_occ,   // slot toward the head holds one
    input  logic                 i_left_gt,
    input  logic [PRIO_BITS-1:0] i_left_prio,
    input  logic [FIELD_W-1:0]   i_left_info,
    input  logic [PRIO_BITS-1:0] i_right_prio,
    input  logic [FIELD_W-1:0]   i_right_info,
    output logic                 o_gt,         // held entry sorts after new one
    output logic [PRIO_BITS-1:0] o_prio,
    output logic [FIELD_W-1:0]   o_info
);

    logic [PRIO_BITS-1:0] r_prio, n_prio;
    logic [FIELD_W-1:0]   r_info, n_info;

    // Strictly greater: equal priorities stay ahead of the newcomer (FIFO ties).
    assign o_gt   = i_occ && (r_prio > i_new_prio);
    assign o_prio = r_prio;
    assign o_info = r_info;

    always_comb begin
        n_prio = r_prio;
        n_info = r_info;
        if (i_ctl.deq) begin
            n_prio = i_right_prio;
            n_info = i_right_info;
        end else if (i_ctl.enq) begin
            if (i_left_gt) begin
                n_prio = i_left_prio;
                n_info = i_left_info;
            end else if (o_gt || (!i_occ && i_left_occ)) begin
                n_prio = i_new_prio;
                n_info = i_new_info;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_info <= n_info;
    end

endmodule

/* hdl/sorted_priority_queue_core.sv */
// Results are registered: a result appears on the output in the cycle after its input transfer.
// Throughput: one operation per cycle while the output is drained; enqueue and
//   dequeue both finish in a single pass through the cell chain.
// Reset: entry count clears to zero and capacity returns to 16. Cell contents
//   are not cleared; no clearing pass, the queue is usable right after reset.
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Sorted-array priority queue built as a chain of cells. Slot 0 always holds
// the smallest priority. Enqueue shifts the larger entries one slot toward
// the tail and drops the new entry into the gap; dequeue pops slot 0 and
// shifts the whole chain one slot toward the head.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH     = DEF_DEPTH,
    parameter int PRIO_BITS = DEF_PRIO_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [15:0]        i_s_axis_tdata,   // [7:0] in_prio, [15:8] in_info
    input  logic [0:0]         i_s_axis_tuser,   // [0] cmd
    // result stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [23:0]        o_m_axis_tdata,   // [7:0] out_prio, [15:8] out_info,
                                                 // [17:16] status, [22:18] count,
                                                 // [23] zero
    // capacity register write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // ---- control / config state ----
    logic [CNT_W-1:0]   r_held, n_held;
    logic [CFG_W-1:0]   r_capacity;

    // ---- output register ----
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out_prio, n_out_prio;
    logic [FIELD_W-1:0] r_out_info, n_out_info;
    t_status            r_out_status, n_out_status;
    logic [COUNT_W-1:0] r_out_count;

    // ---- input decode ----
    logic                 w_accept;
    logic                 w_cmd;
    logic [PRIO_BITS-1:0] w_new_prio;
    logic [FIELD_W-1:0]   w_new_info;
    logic                 w_full;
    logic                 w_empty;
    t_cell_ctl            w_ctl;

    // ---- chain wiring ----
    logic [DEPTH-1:0]     w_occ;
    logic [DEPTH-1:0]     w_gt;
    logic [PRIO_BITS-1:0] w_prio [DEPTH];
    logic [FIELD_W-1:0]   w_info [DEPTH];

    // Single output register: take a new item whenever the slot is free or
    // being emptied in this same cycle.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_cmd      = i_s_axis_tuser[0];
    assign w_new_prio = PRIO_BITS'(i_s_axis_tdata[FIELD_W-1:0]);
    assign w_new_info = i_s_axis_tdata[2*FIELD_W-1:FIELD_W];

    // Capacity above DEPTH saturates; held never exceeds DEPTH.
    assign w_full  = (CMP_W'(r_held) >= CMP_W'(r_capacity)) ||
                     (CMP_W'(r_held) >= CMP_W'(DEPTH));
    assign w_empty = (r_held == '0);

    assign w_ctl.enq = w_accept && (w_cmd == CMD_ENQ) && !w_full;
    assign w_ctl.deq = w_accept && (w_cmd == CMD_DEQ) && !w_empty;

    // Occupancy thermometer: slots below the count hold entries.
    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_occ
            assign w_occ[gi] = (CNT_W'(gi) < r_held);
        end
    endgenerate

    // ---- the cell chain ----
    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                 w_l_occ;
            logic                 w_l_gt;
            logic [PRIO_BITS-1:0] w_l_prio;
            logic [FIELD_W-1:0]   w_l_info;
            logic [PRIO_BITS-1:0] w_r_prio;
            logic [FIELD_W-1:0]   w_r_info;

            if (gi == 0) begin : g_head
                // Head slot: nothing ahead, always eligible for the insert.
                assign w_l_occ  = 1'b1;
                assign w_l_gt   = 1'b0;
                assign w_l_prio = '0;
                assign w_l_info = '0;
            end else begin : g_mid
                assign w_l_occ  = w_occ[gi-1];
                assign w_l_gt   = w_gt[gi-1];
                assign w_l_prio = w_prio[gi-1];
                assign w_l_info = w_info[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                // Tail slot takes filler on a dequeue; it is outside the count.
                assign w_r_prio = '0;
                assign w_r_info = '0;
            end else begin : g_body
                assign w_r_prio = w_prio[gi+1];
                assign w_r_info = w_info[gi+1];
            end

            spq_cell #(
                .PRIO_BITS (PRIO_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_new_prio   (w_new_prio),
                .i_new_info   (w_new_info),
                .i_occ        (w_occ[gi]),
                .i_left_occ   (w_l_occ),
                .i_left_gt    (w_l_gt),
                .i_left_prio  (w_l_prio),
                .i_left_info  (w_l_info),
                .i_right_prio (w_r_prio),
                .i_right_info (w_r_info),
                .o_gt         (w_gt[gi]),
                .o_prio       (w_prio[gi]),
                .o_info       (w_info[gi])
            );
        end
    endgenerate

    // ---- result formation ----
    always_comb begin
        n_held       = r_held;
        n_out_prio   = '0;
        n_out_info   = '0;
        n_out_status = ST_DONE;
        if (w_cmd == CMD_ENQ) begin
            if (w_full) begin
                n_out_status = ST_FULL;
            end else begin
                n_held = r_held + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_out_status = ST_EMPTY;
            end else begin
                n_out_prio = FIELD_W'(w_prio[0]);
                n_out_info = w_info[0];
                n_held     = r_held - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            if (w_accept) begin
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the output register, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_prio   <= n_out_prio;
            r_out_info   <= n_out_info;
            r_out_status <= n_out_status;
            r_out_count  <= COUNT_W'(n_held);
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_count, r_out_status, r_out_info, r_out_prio};

    // ---- checks ----
    `SPQ_ASSERT_NEXT(a_deq_dec, i_clk, i_rst_n, w_accept && (w_cmd == CMD_DEQ) && !w_empty, r_held == $past(r_held) - CNT_W'(1))
    `SPQ_ASSERT_NEXT(a_enq_inc, i_clk, i_rst_n, w_accept && (w_cmd == CMD_ENQ) && !w_full, r_held == $past(r_held) + CNT_W'(1))
    `SPQ_ASSERT_NOW(a_empty_cnt, i_clk, i_rst_n, r_out_valid && (r_out_status == ST_EMPTY), (r_out_count == '0) && (r_out_prio == '0))
    `SPQ_ASSERT_NOW(a_held_max, i_clk, i_rst_n, w_accept, CMP_W'(r_held) <= CMP_W'(DEPTH))

endmodule

/* tb/sv/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Watches the input, result and capacity channels of the sorted priority
// queue, keeps its own sorted copy of the queue and compares every result
// transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [15:0]      i_in_data,    // [7:0] in_prio, [15:8] in_info
    input  logic [0:0]       i_in_user,    // [0] cmd
    input  logic             i_res_valid,
    input  logic             i_res_ready,
    input  logic [23:0]      i_res_data,   // [7:0] prio, [15:8] info, [17:16] status,
                                           // [22:18] count, [23] zero
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Packed so that it lines up with result tdata[22:0].
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        t_status            status;
        logic [FIELD_W-1:0] info;
        logic [FIELD_W-1:0] prio;
    } t_spq_result;

    logic [FIELD_W-1:0] sorted_prio [DEPTH];
    logic [FIELD_W-1:0] sorted_info [DEPTH];
    int unsigned        held_cnt;
    logic [CFG_W-1:0]   cap_reg;
    t_spq_result        due_results [$];
    int                 n_fail;

    // One enqueue or dequeue on the local copy; returns the result it gives.
    function automatic t_spq_result queue_op(input logic cmd, input logic [7:0] prio,
                                             input logic [7:0] info);
        t_spq_result r;
        int unsigned lim;
        int unsigned pos;
        r        = '0;
        r.status = ST_DONE;
        lim      = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        if (cmd == CMD_ENQ) begin
            if (held_cnt >= lim) begin
                r.status = ST_FULL;
            end else begin
                // ties go behind: stop at the first entry not larger
                pos = held_cnt;
                while (pos > 0 && sorted_prio[pos-1] > prio) begin
                    sorted_prio[pos] = sorted_prio[pos-1];
                    sorted_info[pos] = sorted_info[pos-1];
                    pos--;
                end
                sorted_prio[pos] = prio;
                sorted_info[pos] = info;
                held_cnt++;
            end
        end else if (held_cnt == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.prio = sorted_prio[0];
            r.info = sorted_info[0];
            for (int i = 0; i + 1 < held_cnt; i++) begin
                sorted_prio[i] = sorted_prio[i+1];
                sorted_info[i] = sorted_info[i+1];
            end
            held_cnt--;
        end
        r.count = COUNT_W'(held_cnt);
        return r;
    endfunction

    initial begin
        n_fail = 0;
    end

    always @(posedge i_clk) begin
        t_spq_result want;
        t_spq_result got;
        if (!i_rst_n) begin
            held_cnt = 0;
            cap_reg  = CAP_RESET;
            due_results.delete();
        end else begin
            // result side first: it belongs to an earlier input transfer
            if (i_res_valid && i_res_ready) begin
                got = t_spq_result'(i_res_data[22:0]);
                if (due_results.size() == 0) begin
                    $display("%0t: result with nothing due, got %h", $time, i_res_data);
                    n_fail++;
                end else begin
                    want = due_results.pop_front();
                    if (got.prio !== want.prio) begin
                        $display("%0t: out_prio expected %0d, got %0d",
                                 $time, want.prio, got.prio);
                        n_fail++;
                    end
                    if (got.info !== want.info) begin
                        $display("%0t: out_info expected %0d, got %0d",
                                 $time, want.info, got.info);
                        n_fail++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, got.status);
                        n_fail++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: count expected %0d, got %0d",
                                 $time, want.count, got.count);
                        n_fail++;
                    end
                end
                if (i_res_data[23] !== 1'b0) begin
                    $display("%0t: pad bit expected 0, got %b", $time, i_res_data[23]);
                    n_fail++;
                end
            end
            // an input transfer on the same edge still sees the old capacity
            if (i_in_valid && i_in_ready)
                due_results.push_back(queue_op(i_in_user[0], i_in_data[7:0],
                                               i_in_data[15:8]));
            if (i_cfg_valid && i_cfg_ready)
                cap_reg = i_cfg_data;
        end
        o_fail_count <= n_fail;
        o_pending    <= due_results.size();
    end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for sorted_priority_queue_core. A directed run walks
// ties, empty and full queues and capacity changes; random segments then
// swing the queue between fill and drain bursts under several capacities and
// idle patterns. spq_checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spq_pkg::*;

    // cycles with no transfer on any channel before the run is called hung
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               s_valid   = 1'b0;
    logic [15:0]        s_data    = '0;
    logic [0:0]         s_user    = '0;
    logic               m_ready   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               s_ready;
    logic               m_valid;
    logic [23:0]        m_data;
    logic               cfg_ready;
    int                 fail_count;
    int                 pending;
    // idle odds in percent, per cycle
    int                 idle_pct  = 0;
    int                 stall_pct = 0;

    sorted_priority_queue_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // [7:0] in_prio, [15:8] in_info
        .i_s_axis_tuser  (s_user),    // [0] cmd
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),    // [7:0] prio, [15:8] info, [17:16] status,
                                      // [22:18] count, [23] zero
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    spq_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_in_user    (s_user),
        .i_res_valid  (m_valid),
        .i_res_ready  (m_ready),
        .i_res_data   (m_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: ready drops at random with the current stall odds.
    always @(posedge clk)
        m_ready <= ($urandom_range(0, 99) >= stall_pct);

    // One input transfer, preceded by a random gap. The task returns at the
    // edge of the transfer; valid stays high so back-to-back items need no
    // second assignment in that step.
    task automatic send_item(input logic cmd, input logic [7:0] prio,
                             input logic [7:0] info);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {info, prio};
        do @(posedge clk); while (!s_ready);
    endtask

    // Dequeue; the entry fields are don't-care, so fill them with noise.
    task automatic send_deq();
        send_item(CMD_DEQ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Hold the input off until every predicted result has been transferred.
    // The first check waits for the next edge, once the checker has counted the
    // last input transfer.
    task automatic await_drain();
        s_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Capacity writes only happen with nothing in flight.
    task automatic write_cap(input logic [CFG_W-1:0] value);
        await_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random segment: alternating fill and drain bursts so the queue swings
    // between empty and full. Priorities lean on ties and on the extremes.
    task automatic run_segment(input logic [CFG_W-1:0] cap, input int idle,
                               input int stall, input int n_items);
        int unsigned enq_pct;
        logic [7:0]  prio;
        write_cap(cap);
        idle_pct  = idle;
        stall_pct <= stall;
        enq_pct   = 25;
        for (int i = 0; i < n_items; i++) begin
            if (i % 32 == 0)
                enq_pct = (enq_pct == 75) ? 25 : 75;
            // sender waits out the whole pipeline once per segment
            if (i == n_items / 2)
                await_drain();
            case ($urandom_range(0, 3))
                0:       prio = 8'($urandom_range(0, 3));
                1:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: prio = 8'($urandom_range(0, 255));
            endcase
            send_item(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ,
                      prio, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: reset capacity 16 ---
        send_deq();                              // dequeue on empty queue
        send_item(CMD_ENQ, 8'hFF, 8'h00);
        send_item(CMD_ENQ, 8'h00, 8'hFF);
        send_item(CMD_ENQ, 8'h80, 8'hAA);
        send_item(CMD_ENQ, 8'h80, 8'h55);        // tie: must leave after 0xAA
        send_item(CMD_ENQ, 8'h00, 8'h01);        // tie at the lowest priority
        repeat (6) send_deq();                   // last one hits empty again

        // small capacity: third enqueue bounces off a full queue
        write_cap(5'd2);
        send_item(CMD_ENQ, 8'h07, 8'h11);
        send_item(CMD_ENQ, 8'h07, 8'h22);
        send_item(CMD_ENQ, 8'h07, 8'h33);
        send_deq();

        // capacity lowered below the count: entries stay, enqueues bounce
        write_cap(5'd16);
        send_item(CMD_ENQ, 8'd200, 8'h01);
        send_item(CMD_ENQ, 8'd100, 8'h02);
        send_item(CMD_ENQ, 8'd50,  8'h03);
        write_cap(5'd1);
        send_item(CMD_ENQ, 8'd9, 8'h04);
        repeat (2) send_deq();
        send_item(CMD_ENQ, 8'd9, 8'h05);         // count still at capacity
        send_deq();
        send_item(CMD_ENQ, 8'hFF, 8'hFF);        // room again

        // capacity zero rejects every enqueue
        write_cap(5'd0);
        send_item(CMD_ENQ, 8'h01, 8'h01);
        send_deq();

        // --- random segments; capacities above 16 saturate ---
        run_segment(5'd16, 0,  0,  94);
        run_segment(5'd1,  59, 0,  94);
        run_segment(5'd5,  0,  59, 94);
        run_segment(5'd31, 29, 29, 94);
        run_segment(5'd0,  0,  0,  94);
        run_segment(5'd16, 59, 0,  94);
        run_segment(5'd12, 0,  59, 94);
        run_segment(5'd17, 29, 29, 94);

        // drain, then give stray results a chance to show up
        await_drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hang guard: counts cycles with no transfer anywhere.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

endmodule
